// ===== hdl/ccnr_pkg.sv =====
// Package for the circular clip nearest resample block.
// Holds default parameter values, register indexes and the command and region codes.
// Depends on nothing.
package ccnr_pkg;

  localparam int MAP_DIM_DEF      = 512;
  localparam int CLIP_DIM_MAX_DEF = 64;
  localparam int FRAC_BITS_DEF    = 16;

  // Positions saturate at magnitude 2^POS_BITS.
  localparam int POS_BITS = 46;

  localparam logic [31:0] OUTSIDE_VALUE = 32'd31;
  localparam logic [31:0] CIRCLE_VALUE  = 32'd0;

  localparam logic [3:0] CFG_SIGMA    = 4'd0;
  localparam logic [3:0] CFG_X_SPAN   = 4'd1;
  localparam logic [3:0] CFG_Y_SPAN   = 4'd2;
  localparam logic [3:0] CFG_X_ORIGIN = 4'd3;
  localparam logic [3:0] CFG_Y_TOP    = 4'd4;
  localparam logic [3:0] CFG_ROWS     = 4'd5;
  localparam logic [3:0] CFG_COLS     = 4'd6;
  localparam logic [3:0] CFG_CLIP     = 4'd7;

  localparam logic [30:0] SIGMA_RST    = 31'd65536;
  localparam logic [30:0] SPAN_RST     = 31'd65536;
  localparam logic [9:0]  MAP_SIZE_RST = 10'd512;
  localparam logic [6:0]  CLIP_RST     = 7'd32;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_CLIP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REGION_SAMPLED = 2'd0,
    REGION_CIRCLE  = 2'd1,
    REGION_OUTSIDE = 2'd2
  } region_t;

endpackage

// ===== hdl/ccnr_if.sv =====
// Channel interfaces of the circular clip nearest resample block.
// Input item channel, result channel and configuration write channel.
// Depends on nothing.
interface ccnr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [8:0]  map_row;
  logic [8:0]  map_col;
  logic [31:0] map_value;
  logic [31:0] pos_x_q16;
  logic [31:0] pos_y_q16;
  logic [5:0]  out_row;
  logic [5:0]  out_col;
  modport source (output valid, cmd, map_row, map_col, map_value, pos_x_q16, pos_y_q16,
                  out_row, out_col, input ready);
  modport sink (input valid, cmd, map_row, map_col, map_value, pos_x_q16, pos_y_q16,
                out_row, out_col, output ready);
endinterface

interface ccnr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] height_value;
  logic [1:0]  region;
  logic [5:0]  pixel_row;
  logic [5:0]  pixel_col;
  modport source (output valid, height_value, region, pixel_row, pixel_col, input ready);
  modport sink (input valid, height_value, region, pixel_row, pixel_col, output ready);
endinterface

interface ccnr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/circular_clip_nearest_resample_top.sv =====
// Top level of the circular clip nearest resample block.
// Uses ccnr_pkg, the channel interfaces, ccnr_div_pipe and ccnr_ram.
//
// Items arrive on in_ch. A write item (cmd 0) stores map_value in the source map and
// gives no result. A clip item (cmd 1) names one pixel of a square clip around a world
// position and gives one result on out_ch: the nearest map word inside the circle and
// map, 0 outside the inscribed circle, 31 outside the map. Pixels beyond the clip edge
// give no result. Configuration registers are written on cfg_ch, which is always ready;
// the user must do so only while no item is in flight; the block does not enforce this.
// The block takes one item per clock cycle while in_ch.ready is high. Each item passes
// through the three 47-stage quotient pipelines for the step and the two map coordinates,
// followed by the multiply, compare and map read stages.
// Writes and reads reach the map at the same stage, in arrival order.
// When the receiver stalls, one result waits in the output register and the pipeline
// keeps moving until a second result reaches its end; then in_ch.ready drops.
// Reset clears the pipeline and restores the register defaults; map contents are
// undefined until written and are not cleared.
module circular_clip_nearest_resample_top
  import ccnr_pkg::*;
#(
  parameter int MAP_DIM      = MAP_DIM_DEF,
  parameter int CLIP_DIM_MAX = CLIP_DIM_MAX_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ccnr_in_if.sink    in_ch,
  ccnr_out_if.source out_ch,
  ccnr_cfg_if.sink   cfg_ch
);

  localparam int RW   = $clog2(MAP_DIM + 1);
  localparam int CW   = $clog2(CLIP_DIM_MAX + 1);
  localparam int AW   = $clog2(MAP_DIM * MAP_DIM);
  localparam int NW   = 35 + RW;
  localparam int DW   = 31 + CW;
  localparam int VALW = POS_BITS + 2;
  localparam int DUW  = CW + 1;
  localparam int SQW  = 2 * DUW + 1;
  localparam int PW   = VALW + DUW;
  localparam int UW   = PW + 1;
  localparam int DLEN = POS_BITS + 1;

  typedef struct packed {
    logic                  vld;
    logic                  cmd;
    logic                  wok;
    logic [8:0]            wrow;
    logic [8:0]            wcol;
    logic [31:0]           wval;
    logic [5:0]            orow;
    logic [5:0]            ocol;
    logic                  circ;
    logic                  negu;
    logic                  negv;
    logic signed [DUW-1:0] du;
    logic signed [DUW-1:0] dv;
  } side_t;

  logic [30:0] sigma_r, x_span_r, y_span_r;
  logic [31:0] x_origin_r, y_top_r;
  logic [9:0]  map_rows_r, map_cols_r;
  logic [6:0]  clip_size_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r     <= SIGMA_RST;
      x_span_r    <= SPAN_RST;
      y_span_r    <= SPAN_RST;
      x_origin_r  <= '0;
      y_top_r     <= '0;
      map_rows_r  <= MAP_SIZE_RST;
      map_cols_r  <= MAP_SIZE_RST;
      clip_size_r <= CLIP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SIGMA:    sigma_r     <= cfg_ch.data[30:0];
        CFG_X_SPAN:   x_span_r    <= cfg_ch.data[30:0];
        CFG_Y_SPAN:   y_span_r    <= cfg_ch.data[30:0];
        CFG_X_ORIGIN: x_origin_r  <= cfg_ch.data;
        CFG_Y_TOP:    y_top_r     <= cfg_ch.data;
        CFG_ROWS:     map_rows_r  <= cfg_ch.data[9:0];
        CFG_COLS:     map_cols_r  <= cfg_ch.data[9:0];
        CFG_CLIP:     clip_size_r <= cfg_ch.data[6:0];
        default: begin
        end
      endcase
    end
  end

  logic [RW-1:0] rows_eff, cols_eff;
  logic [CW-1:0] c_eff, h;
  logic [30:0]   xs, ys;

  assign rows_eff = RW'((32'(map_rows_r) > MAP_DIM) ? MAP_DIM : 32'(map_rows_r));
  assign cols_eff = RW'((32'(map_cols_r) > MAP_DIM) ? MAP_DIM : 32'(map_cols_r));
  assign c_eff = (clip_size_r == '0) ? CW'(1) :
                 CW'((32'(clip_size_r) > CLIP_DIM_MAX) ? CLIP_DIM_MAX : 32'(clip_size_r));
  assign h  = c_eff >> 1;
  assign xs = (x_span_r == '0) ? 31'd1 : x_span_r;
  assign ys = (y_span_r == '0) ? 31'd1 : y_span_r;

  logic adv;

  // Stage 0: input decode.
  logic signed [DUW-1:0] du_in, dv_in;
  logic signed [SQW-1:0] du_x, dv_x, h_x;
  logic                  drop;
  side_t                 s0_sb, s1_sb;
  logic signed [32:0]    s0_dy, s0_dx;
  logic [34:0]           s0_st12;
  logic [DW-1:0]         s0_den_s;

  assign du_in = DUW'(in_ch.out_row) - DUW'(h);
  assign dv_in = DUW'(in_ch.out_col) - DUW'(h);
  assign du_x  = SQW'(du_in);
  assign dv_x  = SQW'(dv_in);
  assign h_x   = SQW'(h);
  assign drop  = (32'(in_ch.out_row) >= 32'(c_eff)) || (32'(in_ch.out_col) >= 32'(c_eff));

  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_sb.vld <= 1'b0;
    end else if (adv) begin
      s0_sb.vld <= in_ch.valid && !(in_ch.cmd == CMD_CLIP && drop);
    end
    if (adv) begin
      s0_sb.cmd  <= in_ch.cmd;
      s0_sb.wok  <= (32'(in_ch.map_row) < MAP_DIM) && (32'(in_ch.map_col) < MAP_DIM);
      s0_sb.wrow <= in_ch.map_row;
      s0_sb.wcol <= in_ch.map_col;
      s0_sb.wval <= in_ch.map_value;
      s0_sb.orow <= in_ch.out_row;
      s0_sb.ocol <= in_ch.out_col;
      s0_sb.circ <= (du_x * du_x + dv_x * dv_x) > (h_x * h_x);
      s0_sb.negu <= 1'b0;
      s0_sb.negv <= 1'b0;
      s0_sb.du   <= du_in;
      s0_sb.dv   <= dv_in;
      s0_dy      <= $signed({y_top_r[31], y_top_r}) -
                    $signed({in_ch.pos_y_q16[31], in_ch.pos_y_q16});
      s0_dx      <= $signed({in_ch.pos_x_q16[31], in_ch.pos_x_q16}) -
                    $signed({x_origin_r[31], x_origin_r});
      s0_st12    <= 35'(sigma_r) * 35'd12;
      s0_den_s   <= DW'(xs) * DW'(c_eff);
    end
  end

  // Stage 1: numerator magnitudes and denominators.
  logic [32:0]   abs_dy, abs_dx;
  logic [NW-1:0] s1_mag_s, s1_mag_u, s1_mag_v;
  logic [DW-1:0] s1_den_s, s1_den_u, s1_den_v;
  side_t         s1_in;

  assign abs_dy = s0_dy[32] ? 33'(-s0_dy) : 33'(s0_dy);
  assign abs_dx = s0_dx[32] ? 33'(-s0_dx) : 33'(s0_dx);

  always_comb begin
    s1_in      = s0_sb;
    s1_in.negu = s0_dy[32];
    s1_in.negv = s0_dx[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_sb.vld <= 1'b0;
    end else if (adv) begin
      s1_sb.vld <= s0_sb.vld;
    end
    if (adv) begin
      s1_sb[$bits(side_t)-2:0] <= s1_in[$bits(side_t)-2:0];
      s1_mag_s   <= NW'(s0_st12) * NW'(cols_eff);
      s1_mag_u   <= NW'(abs_dy) * NW'(rows_eff);
      s1_mag_v   <= NW'(abs_dx) * NW'(cols_eff);
      s1_den_s   <= s0_den_s;
      s1_den_u   <= DW'(ys);
      s1_den_v   <= DW'(xs);
    end
  end

  // Quotient pipelines, with the item's sideband running alongside.
  logic [POS_BITS-1:0] q_s, q_u, q_v;
  logic                sat_s, sat_u, sat_v;

  ccnr_div_pipe #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_step (
    .clk(clk), .adv(adv), .mag_i(s1_mag_s), .den_i(s1_den_s), .q_o(q_s), .sat_o(sat_s)
  );
  ccnr_div_pipe #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk(clk), .adv(adv), .mag_i(s1_mag_u), .den_i(s1_den_u), .q_o(q_u), .sat_o(sat_u)
  );
  ccnr_div_pipe #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk(clk), .adv(adv), .mag_i(s1_mag_v), .den_i(s1_den_v), .q_o(q_v), .sat_o(sat_v)
  );

  side_t sb_r [DLEN+1];
  assign sb_r[0] = s1_sb;

  for (genvar k = 1; k <= DLEN; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r[k].vld <= 1'b0;
      end else if (adv) begin
        sb_r[k].vld <= sb_r[k-1].vld;
      end
      if (adv) begin
        sb_r[k][$bits(side_t)-2:0] <= sb_r[k-1][$bits(side_t)-2:0];
      end
    end
  end

  // Stage A: signed, saturated step and center coordinates.
  localparam logic [VALW-1:0] CAP = VALW'(1) << POS_BITS;
  logic [VALW-1:0]        val_s, val_u, val_v;
  side_t                  a_sb, b_sb, c_sb, d_sb, e_sb;
  logic signed [VALW-1:0] a_step, a_u, a_v, b_u, b_v;
  logic signed [PW-1:0]   b_pu, b_pv;
  logic signed [UW-1:0]   c_u, c_v;

  assign val_s = sat_s ? CAP : VALW'(q_s);
  assign val_u = sat_u ? CAP : VALW'(q_u);
  assign val_v = sat_v ? CAP : VALW'(q_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_sb.vld <= 1'b0;
      b_sb.vld <= 1'b0;
      c_sb.vld <= 1'b0;
    end else if (adv) begin
      a_sb.vld <= sb_r[DLEN].vld;
      b_sb.vld <= a_sb.vld;
      c_sb.vld <= b_sb.vld;
    end
    if (adv) begin
      a_sb[$bits(side_t)-2:0] <= sb_r[DLEN][$bits(side_t)-2:0];
      a_step <= $signed(val_s);
      a_u    <= sb_r[DLEN].negu ? -$signed(val_u) : $signed(val_u);
      a_v    <= sb_r[DLEN].negv ? -$signed(val_v) : $signed(val_v);
      // Stage B: pixel offsets times the step.
      b_sb[$bits(side_t)-2:0] <= a_sb[$bits(side_t)-2:0];
      b_pu <= PW'(a_sb.du) * PW'(a_step);
      b_pv <= PW'(a_sb.dv) * PW'(a_step);
      b_u  <= a_u;
      b_v  <= a_v;
      // Stage C: source position.
      c_sb[$bits(side_t)-2:0] <= b_sb[$bits(side_t)-2:0];
      c_u <= UW'(b_u) + UW'(b_pu);
      c_v <= UW'(b_v) + UW'(b_pv);
    end
  end

  // Stage D: region, rounding, clamping and map address.
  localparam logic [UW-1:0] HALF = UW'(1) << (FRAC_BITS - 1);
  logic [UW-1:0] lim_u, lim_v, rnd_u, rnd_v;
  logic [RW-1:0] ri, ci, rows_m1, cols_m1;
  logic          outside;
  region_t       region_nxt, d_region, e_region;
  logic [AW-1:0] d_raddr, waddr;
  logic          ram_we, ram_re;
  logic [31:0]   ram_q;

  assign lim_u   = UW'(rows_eff) << FRAC_BITS;
  assign lim_v   = UW'(cols_eff) << FRAC_BITS;
  assign outside = c_u[UW-1] || c_v[UW-1] ||
                   ($unsigned(c_u) >= lim_u) || ($unsigned(c_v) >= lim_v);
  assign rnd_u   = ($unsigned(c_u) + HALF) >> FRAC_BITS;
  assign rnd_v   = ($unsigned(c_v) + HALF) >> FRAC_BITS;
  assign rows_m1 = rows_eff - RW'(1);
  assign cols_m1 = cols_eff - RW'(1);
  assign ri      = (RW'(rnd_u) > rows_m1) ? rows_m1 : RW'(rnd_u);
  assign ci      = (RW'(rnd_v) > cols_m1) ? cols_m1 : RW'(rnd_v);

  always_comb begin
    if (c_sb.circ) begin
      region_nxt = REGION_CIRCLE;
    end else if (outside) begin
      region_nxt = REGION_OUTSIDE;
    end else begin
      region_nxt = REGION_SAMPLED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_sb.vld <= 1'b0;
      e_sb.vld <= 1'b0;
    end else if (adv) begin
      d_sb.vld <= c_sb.vld;
      e_sb.vld <= d_sb.vld;
    end
    if (adv) begin
      d_sb[$bits(side_t)-2:0] <= c_sb[$bits(side_t)-2:0];
      d_region <= region_nxt;
      d_raddr  <= AW'(ri) * AW'(MAP_DIM) + AW'(ci);
      e_sb[$bits(side_t)-2:0] <= d_sb[$bits(side_t)-2:0];
      e_region <= d_region;
    end
  end

  assign waddr  = AW'(d_sb.wrow) * AW'(MAP_DIM) + AW'(d_sb.wcol);
  assign ram_we = adv && d_sb.vld && d_sb.cmd == CMD_WRITE && d_sb.wok;
  assign ram_re = adv && d_sb.vld && d_sb.cmd == CMD_CLIP && d_region == REGION_SAMPLED;

  ccnr_ram #(.WIDTH(32), .DEPTH(MAP_DIM * MAP_DIM)) u_map (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(d_sb.wval),
    .re(ram_re), .raddr(d_raddr), .rdata(ram_q)
  );

  // Output register.
  logic        e_res, out_valid_r;
  logic [31:0] out_value_r;
  region_t     out_region_r;
  logic [5:0]  out_row_r, out_col_r;

  assign e_res = e_sb.vld && e_sb.cmd == CMD_CLIP;
  assign adv   = !e_res || !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && e_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && e_res) begin
      case (e_region)
        REGION_SAMPLED: out_value_r <= ram_q;
        REGION_CIRCLE:  out_value_r <= CIRCLE_VALUE;
        default:        out_value_r <= OUTSIDE_VALUE;
      endcase
      out_region_r <= e_region;
      out_row_r    <= e_sb.orow;
      out_col_r    <= e_sb.ocol;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.height_value = out_value_r;
  assign out_ch.region       = out_region_r;
  assign out_ch.pixel_row    = out_row_r;
  assign out_ch.pixel_col    = out_col_r;

  a_circle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.region == REGION_CIRCLE |-> out_ch.height_value == CIRCLE_VALUE)
    else $error("circle pixel with nonzero value");

  a_outside_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.region == REGION_OUTSIDE |-> out_ch.height_value == OUTSIDE_VALUE)
    else $error("outside pixel with wrong value");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("map written and read in one cycle");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without a blocked result");

endmodule

// ===== hdl/ccnr_ram.sv =====
// Generic simple dual port RAM with one write port and a registered read port.
// Depends on nothing.
module ccnr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ccnr_div_pipe.sv =====
// Pipelined restoring divider: floor(mag * 2^FRAC_BITS / den), one quotient bit per stage.
// Flags quotients at or above 2^POS_BITS as saturated. Uses ccnr_pkg.
module ccnr_div_pipe
  import ccnr_pkg::*;
#(
  parameter int NW        = 45,
  parameter int DW        = 38,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                adv,
  input  logic [NW-1:0]       mag_i,
  input  logic [DW-1:0]       den_i,
  output logic [POS_BITS-1:0] q_o,
  output logic                sat_o
);

  localparam int SH   = POS_BITS - FRAC_BITS;
  localparam int CMPW = ((NW > DW + SH) ? NW : DW + SH) + 1;

  logic [DW-1:0]       r_r   [POS_BITS+1];
  logic [NW-1:0]       mag_r [POS_BITS+1];
  logic [DW-1:0]       den_r [POS_BITS+1];
  logic [POS_BITS-1:0] q_r   [POS_BITS+1];
  logic                sat_r [POS_BITS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r[0] <= CMPW'(mag_i) >= (CMPW'(den_i) << SH);
      r_r[0]   <= DW'(mag_i >> SH);
      mag_r[0] <= mag_i;
      den_r[0] <= den_i;
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < POS_BITS; i++) begin : g_stage
    localparam int J = POS_BITS - 1 - i;
    logic          dbit;
    logic [DW:0]   trial;
    logic          ge;
    if (J >= FRAC_BITS && J - FRAC_BITS < NW) begin : g_bit
      assign dbit = mag_r[i][J-FRAC_BITS];
    end else begin : g_zero
      assign dbit = 1'b0;
    end
    assign trial = {r_r[i], dbit};
    assign ge    = trial >= {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        r_r[i+1]   <= ge ? DW'(trial - {1'b0, den_r[i]}) : DW'(trial);
        q_r[i+1]   <= q_r[i] | (POS_BITS'(ge) << J);
        mag_r[i+1] <= mag_r[i];
        den_r[i+1] <= den_r[i];
        sat_r[i+1] <= sat_r[i];
      end
    end
  end

  assign q_o   = q_r[POS_BITS];
  assign sat_o = sat_r[POS_BITS];

endmodule
